// File: src/imadec_pkg.sv
package imadec_pkg;

    // field widths
    localparam int unsigned SampleWidth = 16;
    localparam int unsigned IndexWidth  = 6;
    localparam int unsigned CodeWidth   = 4;
    localparam int unsigned PosWidth    = 7;
    localparam int unsigned StepWidth   = 15;

    // beat modes
    localparam logic MODE_HEADER = 1'b0;
    localparam logic MODE_CODE   = 1'b1;

    // step position and sample limits
    localparam logic [PosWidth-1:0]       POS_MAX  = 7'd88;
    localparam logic signed [17:0]        PCM_MIN  = -18'sd32768;
    localparam logic signed [17:0]        PCM_MAX  = 18'sd32767;
    localparam logic [2:0]                MAG_MASK = 3'h7;

    // input beat
    typedef struct packed {
        logic                          mode;
        logic signed [SampleWidth-1:0] header_sample;
        logic [IndexWidth-1:0]         header_index;
        logic [CodeWidth-1:0]          code;
    } t_in_beat;

    // output beat
    typedef struct packed {
        logic signed [SampleWidth-1:0] pcm_sample;
        logic [PosWidth-1:0]           step_position;
    } t_out_beat;

    // decoder state carried from beat to beat
    typedef struct packed {
        logic signed [SampleWidth-1:0] predictor;
        logic [PosWidth-1:0]           step_pointer;
    } t_dec_state;

    // quantizer step sizes
    localparam logic [StepWidth-1:0] STEP_TABLE [0:88] = '{
        15'd7,     15'd8,     15'd9,     15'd10,    15'd11,    15'd12,
        15'd13,    15'd14,    15'd16,    15'd17,    15'd19,    15'd21,
        15'd23,    15'd25,    15'd28,    15'd31,    15'd34,    15'd37,
        15'd41,    15'd45,    15'd50,    15'd55,    15'd60,    15'd66,
        15'd73,    15'd80,    15'd88,    15'd97,    15'd107,   15'd118,
        15'd130,   15'd143,   15'd157,   15'd173,   15'd190,   15'd209,
        15'd230,   15'd253,   15'd279,   15'd307,   15'd337,   15'd371,
        15'd408,   15'd449,   15'd494,   15'd544,   15'd598,   15'd658,
        15'd724,   15'd796,   15'd876,   15'd963,   15'd1060,  15'd1166,
        15'd1282,  15'd1411,  15'd1552,  15'd1707,  15'd1878,  15'd2066,
        15'd2272,  15'd2499,  15'd2749,  15'd3024,  15'd3327,  15'd3660,
        15'd4026,  15'd4428,  15'd4871,  15'd5358,  15'd5894,  15'd6484,
        15'd7132,  15'd7845,  15'd8630,  15'd9493,  15'd10442, 15'd11487,
        15'd12635, 15'd13899, 15'd15289, 15'd16818, 15'd18500, 15'd20350,
        15'd22385, 15'd24623, 15'd27086, 15'd29794, 15'd32767
    };

    // step position adjustment by code magnitude
    function automatic logic signed [7:0] pos_delta(input logic [2:0] mag);
        logic signed [7:0] d;
        unique case (mag)
            3'd4:    d = 8'sd2;
            3'd5:    d = 8'sd4;
            3'd6:    d = 8'sd6;
            3'd7:    d = 8'sd8;
            default: d = -8'sd1;
        endcase
        return d;
    endfunction

endpackage

// File: src/imadec_step.sv
module imadec_step (
    input  imadec_pkg::t_in_beat   i_beat,
    input  imadec_pkg::t_dec_state i_state,
    output imadec_pkg::t_dec_state o_state
);

    logic [imadec_pkg::PosWidth-1:0]  pos_lim;
    logic [imadec_pkg::StepWidth-1:0] step;
    logic [2:0]                       mag;
    logic [17:0]                      prod;
    logic [16:0]                      diff;
    logic signed [17:0]               sum;
    logic signed [17:0]               sat;
    logic signed [7:0]                pos_sum;
    logic [imadec_pkg::PosWidth-1:0]  pos_new;

    // step lookup with position held inside the table
    always_comb begin
        pos_lim = (i_state.step_pointer > imadec_pkg::POS_MAX) ?
                  imadec_pkg::POS_MAX : i_state.step_pointer;
        step    = imadec_pkg::STEP_TABLE[pos_lim];
        mag     = i_beat.code[2:0] & imadec_pkg::MAG_MASK;
    end

    // difference magnitude: (step * mag) / 4 + step / 8
    always_comb begin
        prod = {3'b000, step} * {15'd0, mag};
        diff = 17'(prod >> 2) + 17'(step >> 3);
    end

    // signed prediction update and saturation
    always_comb begin
        if (i_beat.code[3]) begin
            sum = 18'(i_state.predictor) - $signed({1'b0, diff});
        end else begin
            sum = 18'(i_state.predictor) + $signed({1'b0, diff});
        end
        if (sum < imadec_pkg::PCM_MIN) begin
            sat = imadec_pkg::PCM_MIN;
        end else if (sum > imadec_pkg::PCM_MAX) begin
            sat = imadec_pkg::PCM_MAX;
        end else begin
            sat = sum;
        end
    end

    // step position adaptation and clamp
    always_comb begin
        pos_sum = $signed({1'b0, pos_lim}) + imadec_pkg::pos_delta(mag);
        if (pos_sum < 8'sd0) begin
            pos_new = '0;
        end else if (pos_sum > $signed({1'b0, imadec_pkg::POS_MAX})) begin
            pos_new = imadec_pkg::POS_MAX;
        end else begin
            pos_new = pos_sum[imadec_pkg::PosWidth-1:0];
        end
    end

    // header beats load the state directly
    always_comb begin
        unique case (i_beat.mode)
            imadec_pkg::MODE_HEADER: begin
                o_state.predictor    = i_beat.header_sample;
                o_state.step_pointer = {1'b0, i_beat.header_index};
            end
            default: begin
                o_state.predictor    = sat[imadec_pkg::SampleWidth-1:0];
                o_state.step_pointer = pos_new;
            end
        endcase
    end

endmodule

// File: src/ima_adpcm_decoder.sv
// 4-bit IMA ADPCM decoder.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries one beat per
// item: a header beat (mode 0) loads predictor and step index and returns
// the header sample; a code beat (mode 1) decodes one nibble against the
// running state. Every input beat yields exactly one output beat on
// (o_out_valid / i_out_ready / o_out_data) with the sample and new index.
// An accepted beat lands in the input register; once the output register
// is empty or being read, it is decoded through the step table, a 15x3
// multiply and the saturating add, and written to the output register.
// One beat per cycle is sustained while the receiver keeps taking beats;
// the table lookup, add and clamp form the only loop, which the state
// register closes.
// When the receiver stalls, the output register holds its beat and the
// input register keeps one more, so ready drops only once both are full.
// Synchronous reset clears predictor and step index to zero and empties
// both registers; a code beat before any header decodes from zero state.
module ima_adpcm_decoder (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  imadec_pkg::t_in_beat  i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output imadec_pkg::t_out_beat o_out_data
);

    logic                   r_in_valid;
    imadec_pkg::t_in_beat   r_in;
    logic                   r_out_valid;
    imadec_pkg::t_out_beat  r_out;
    imadec_pkg::t_dec_state r_state;
    imadec_pkg::t_dec_state n_state;
    logic                   advance;

    // handshake control
    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // decode datapath
    imadec_step u_step (
        .i_beat  (r_in),
        .i_state (r_state),
        .o_state (n_state)
    );

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    // decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out.pcm_sample    <= n_state.predictor;
            r_out.step_position <= n_state.step_pointer;
        end
    end

endmodule
